// ----- hdl/prbp_pkg.sv -----
// ----------------------------------------------------------------------------
// Program barcode row packer: shared types and constants
// Word formats of both channels, the byte class code that the front end
// attaches to every program byte, and the byte values used by the END fixup.
// ----------------------------------------------------------------------------
`default_nettype none

package prbp_pkg;

  // Default geometry: data bytes per row and settling window behind a row.
  localparam int ROW_BYTES_DEF = 13;
  localparam int LOOKAHEAD_DEF = 16;

  // Entries of the queue between front end and back end.
  localparam int QUEUE_DEPTH = 2;

  // Digit bytes form runs; the type byte of a row starts at this value.
  localparam logic [7:0] DIGIT_LO  = 8'h10;
  localparam logic [7:0] DIGIT_HI  = 8'h1C;
  localparam logic [7:0] TYPE_BASE = 8'h10;

  // Final END instruction, written in place or appended.
  localparam logic [7:0] END_B0 = 8'hC0;
  localparam logic [7:0] END_B1 = 8'h00;
  localparam logic [7:0] END_B2 = 8'h2F;

  // Instruction class of a byte when it opens an instruction.
  typedef enum logic [2:0] {
    CL_ONE,     // single byte
    CL_DIGIT,   // part of a digit run
    CL_TWO,     // two bytes
    CL_NEXT,    // length taken from the low nibble of the next byte
    CL_CTHIRD,  // three bytes, or longer if the third byte has bit 7 set
    CL_THREE,   // three bytes
    CL_FLEN     // length from its own low nibble
  } cls_e;

  typedef struct packed {
    logic [7:0] prog_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       row_done;
    logic       stream_done;
  } out_word_t;

  // One entry of the byte window.
  typedef struct packed {
    cls_e       cls;
    logic [7:0] data;
  } win_ent_t;

  // One word of the queue.
  typedef struct packed {
    win_ent_t ent;
    logic     final_byte;
  } q_item_t;

endpackage

`default_nettype wire

// ----- hdl/prbp_front.sv -----
// ----------------------------------------------------------------------------
// Program barcode row packer: front end
// Accepts program bytes, tags each with its instruction class and holds the
// tagged word in a register until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module prbp_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire prbp_pkg::in_word_t in_word_i,
  output logic                    push_valid_o,
  input  wire logic               push_ready_i,
  output prbp_pkg::q_item_t       push_item_o
);
  import prbp_pkg::*;

  logic    v_q, v_d;
  q_item_t item_q;

  // Class of a byte as the first byte of an instruction.
  function automatic cls_e classify(input logic [7:0] b);
    cls_e c;
    c = CL_ONE;
    case (b[7:4])
      4'h1: begin
        c = (b >= DIGIT_LO && b <= DIGIT_HI) ? CL_DIGIT : CL_NEXT;
      end
      4'h9, 4'hA, 4'hB: begin
        c = CL_TWO;
      end
      4'hC: begin
        c = (b[3:1] == 3'b111) ? CL_TWO : CL_CTHIRD;
      end
      4'hD, 4'hE: begin
        c = CL_THREE;
      end
      4'hF: begin
        c = CL_FLEN;
      end
      default: begin
        c = CL_ONE;
      end
    endcase
    return c;
  endfunction

  // The holding register takes a new word when empty or when it drains.
  assign in_ready_o   = !v_q || push_ready_i;
  assign push_valid_o = v_q;
  assign push_item_o  = item_q;

  always_comb begin
    v_d = v_q;
    if (in_valid_i && in_ready_o) begin
      v_d = 1'b1;
    end else if (push_ready_i) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.ent.cls    <= classify(in_word_i.prog_byte);
      item_q.ent.data   <= in_word_i.prog_byte;
      item_q.final_byte <= in_word_i.final_byte;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/prbp_fifo.sv -----
// ----------------------------------------------------------------------------
// Program barcode row packer: decoupling queue
// A short first-in first-out queue of tagged words between the front end and
// the back end, so that either side can stall without holding the other.
// ----------------------------------------------------------------------------
`default_nettype none

module prbp_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire prbp_pkg::q_item_t push_item_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_i,
  output prbp_pkg::q_item_t      pop_item_o
);
  import prbp_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  q_item_t         slot_q [QUEUE_DEPTH];
  logic [PW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CW'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = slot_q[rp_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Pointer and count update with wrap at the queue depth.
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PW'(1);
    end
    if (do_pop) begin
      rp_d = (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/prbp_back.sv -----
// ----------------------------------------------------------------------------
// Program barcode row packer: back end
// Holds the byte window in a circular memory, applies the END fixup, scans
// each row to split it into instructions and to build its checksum, then
// sends the header and the data bytes through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module prbp_back #(
  parameter int ROW_BYTES = prbp_pkg::ROW_BYTES_DEF,
  parameter int LOOKAHEAD = prbp_pkg::LOOKAHEAD_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  output logic                   q_pop_o,
  input  wire prbp_pkg::q_item_t q_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output prbp_pkg::out_word_t    out_word_o
);
  import prbp_pkg::*;

  localparam int WIN   = ROW_BYTES + LOOKAHEAD + 3;
  localparam int TRIG  = ROW_BYTES + LOOKAHEAD;
  localparam int AW    = $clog2(WIN);
  localparam int DEPTH = 2 ** AW;
  localparam int FW    = $clog2(WIN + 1);
  localparam int LW    = $clog2(ROW_BYTES + 1);
  localparam int SW    = $clog2(ROW_BYTES + 2);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIX  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_CK   = 3'd3;
  localparam logic [2:0] S_HDR  = 3'd4;
  localparam logic [2:0] S_DRD  = 3'd5;
  localparam logic [2:0] S_DWR  = 3'd6;

  // Length still to be resolved from a later byte of the instruction.
  localparam logic [1:0] P_NONE = 2'd0;
  localparam logic [1:0] P_NEXT = 2'd1;
  localparam logic [1:0] P_C1   = 2'd2;
  localparam logic [1:0] P_C2   = 2'd3;

  // Header positions.
  localparam logic [1:0] H_COUNT = 2'd0;
  localparam logic [1:0] H_SUM   = 2'd1;
  localparam logic [1:0] H_TYPE  = 2'd2;
  localparam logic [1:0] H_OV    = 2'd3;

  win_ent_t        mem [DEPTH];
  win_ent_t        rdata_q;
  logic [AW-1:0]   raddr, waddr;
  logic            we;
  win_ent_t        wdata;

  logic [2:0]      state_q, state_d;
  logic [AW-1:0]   base_q, base_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic [7:0]      sum_q, sum_d;
  logic [3:0]      seq_q, seq_d;
  logic            run_q, run_d;
  logic [7:0]      dcnt_q, dcnt_d;
  logic [3:0]      carry_q, carry_d;
  logic [1:0]      pend_q, pend_d;
  logic [7:0]      prev1_q, prev1_d, prev2_q, prev2_d;
  logic            patch_q, patch_d;
  logic [1:0]      fx_q, fx_d;
  logic            flush_q, flush_d;
  logic [LW-1:0]   len_q, len_d;
  logic            last_q, last_d;
  logic            peek_q, peek_d;
  logic [SW-1:0]   ri_q, ri_d, pj_q, pj_d;
  logic            pv_q, pv_d;
  logic            first_q, first_d;
  logic [3:0]      ns_q, ns_d, icnt_q, icnt_d, ne_q, ne_d;
  logic [1:0]      hk_q, hk_d;
  logic [LW-1:0]   di_q, di_d;
  logic            out_valid_q, out_valid_d;
  out_word_t       out_q, out_d;

  logic            can_load, out_load;
  logic            cont, lastd;
  logic [SW-1:0]   lastj;
  logic [7:0]      type_b, ov_b;
  logic            row_go;
  logic [FW-1:0]   row_fill, fill_new, fill_after;

  // Add with end-around carry.
  function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? (s[7:0] + 8'd1) : s[7:0];
  endfunction

  assign can_load = !out_valid_q || out_ready_i;
  assign type_b   = TYPE_BASE + {4'h0, seq_q};
  assign ov_b     = {ns_q, ne_q};
  assign lastj    = peek_q ? SW'(len_q) : (SW'(len_q) - SW'(1));
  assign lastd    = (di_q == (len_q - LW'(1)));

  // Does the scanned byte continue the instruction in progress?
  assign cont = run_q ? ((rdata_q.cls == CL_DIGIT) && (dcnt_q != 8'hFF))
                      : (carry_q != 4'd0);

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    fill_d     = fill_q;
    sum_d      = sum_q;
    seq_d      = seq_q;
    run_d      = run_q;
    dcnt_d     = dcnt_q;
    carry_d    = carry_q;
    pend_d     = pend_q;
    prev1_d    = prev1_q;
    prev2_d    = prev2_q;
    patch_d    = patch_q;
    fx_d       = fx_q;
    flush_d    = flush_q;
    len_d      = len_q;
    last_d     = last_q;
    peek_d     = peek_q;
    ri_d       = ri_q;
    pj_d       = pj_q;
    pv_d       = 1'b0;
    first_d    = first_q;
    ns_d       = ns_q;
    icnt_d     = icnt_q;
    ne_d       = ne_q;
    hk_d       = hk_q;
    di_d       = di_q;
    out_load   = 1'b0;
    out_d      = out_q;
    raddr      = base_q;
    we         = 1'b0;
    waddr      = base_q;
    wdata      = '0;
    q_pop_o    = 1'b0;
    row_go     = 1'b0;
    row_fill   = fill_q;
    fill_new   = fill_q + FW'(1);
    fill_after = fill_q - FW'(len_q);

    case (state_q)
      S_IDLE: begin
        // Append the next word; once the window holds a row and its lookahead, one row settles.
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          we      = 1'b1;
          waddr   = base_q + AW'(fill_q);
          wdata   = q_item_i.ent;
          fill_d  = fill_new;
          prev2_d = prev1_q;
          prev1_d = q_item_i.ent.data;
          if (q_item_i.final_byte) begin
            patch_d = (fill_new >= FW'(3)) && (prev2_q[7:4] == END_B0[7:4]) &&
                      !q_item_i.ent.data[7];
            fx_d    = 2'd0;
            flush_d = 1'b1;
            state_d = S_FIX;
          end else if (fill_new >= FW'(TRIG)) begin
            row_go   = 1'b1;
            row_fill = fill_new;
          end
        end
      end
      S_FIX: begin
        // Write the END over the last three bytes or after them.
        we = 1'b1;
        if (patch_q) begin
          waddr = base_q + AW'(fill_q) - AW'(3) + AW'(fx_q);
        end else begin
          waddr  = base_q + AW'(fill_q);
          fill_d = fill_new;
        end
        case (fx_q)
          2'd0: begin
            wdata.cls  = CL_CTHIRD;
            wdata.data = END_B0;
          end
          2'd1: begin
            wdata.cls  = CL_ONE;
            wdata.data = END_B1;
          end
          default: begin
            wdata.cls  = CL_ONE;
            wdata.data = END_B2;
          end
        endcase
        fx_d = fx_q + 2'd1;
        if (fx_q == 2'd2) begin
          row_go   = 1'b1;
          row_fill = patch_q ? fill_q : fill_new;
        end
      end
      S_SCAN: begin
        // Issue one window read per cycle; the data is registered and arrives in the next cycle.
        raddr = base_q + AW'(ri_q);
        if (ri_q <= lastj) begin
          pv_d = 1'b1;
          pj_d = ri_q;
          ri_d = ri_q + SW'(1);
        end
        if (pv_q) begin
          if (pj_q < SW'(len_q)) begin
            sum_d = eac_add(sum_q, rdata_q.data);
            if (cont) begin
              icnt_d = icnt_q + 4'd1;
              if (first_q) begin
                ns_d = ns_q + 4'd1;
              end
              if (run_q) begin
                dcnt_d = dcnt_q + 8'd1;
              end else begin
                case (pend_q)
                  P_NEXT: begin
                    carry_d = rdata_q.data[3:0];
                    pend_d  = P_NONE;
                  end
                  P_C1: begin
                    carry_d = carry_q - 4'd1;
                    pend_d  = P_C2;
                  end
                  P_C2: begin
                    carry_d = rdata_q.data[7] ? rdata_q.data[3:0] : 4'd0;
                    pend_d  = P_NONE;
                  end
                  default: begin
                    carry_d = carry_q - 4'd1;
                  end
                endcase
              end
            end else begin
              // This byte opens a new instruction.
              first_d = 1'b0;
              icnt_d  = 4'd1;
              pend_d  = P_NONE;
              run_d   = 1'b0;
              dcnt_d  = 8'd0;
              carry_d = 4'd0;
              case (rdata_q.cls)
                CL_DIGIT: begin
                  run_d  = 1'b1;
                  dcnt_d = 8'd1;
                end
                CL_TWO: begin
                  carry_d = 4'd1;
                end
                CL_NEXT: begin
                  carry_d = 4'd1;
                  pend_d  = P_NEXT;
                end
                CL_CTHIRD: begin
                  carry_d = 4'd2;
                  pend_d  = P_C1;
                end
                CL_THREE: begin
                  carry_d = 4'd2;
                end
                CL_FLEN: begin
                  carry_d = rdata_q.data[3:0];
                end
                default: begin
                  carry_d = 4'd0;
                end
              endcase
            end
          end else begin
            // First byte of the next row: does the last instruction go on?
            ne_d = cont ? icnt_q : 4'd0;
          end
          if (pj_q == lastj) begin
            state_d = S_CK;
          end
        end
      end
      S_CK: begin
        sum_d   = eac_add(eac_add(sum_q, type_b), ov_b);
        hk_d    = H_COUNT;
        state_d = S_HDR;
      end
      S_HDR: begin
        if (can_load) begin
          out_load          = 1'b1;
          out_d.row_done    = 1'b0;
          out_d.stream_done = 1'b0;
          case (hk_q)
            H_COUNT: out_d.code_byte = 8'(len_q) + 8'd2;
            H_SUM:   out_d.code_byte = sum_q;
            H_TYPE:  out_d.code_byte = type_b;
            default: out_d.code_byte = ov_b;
          endcase
          hk_d = hk_q + 2'd1;
          if (hk_q == H_OV) begin
            di_d    = '0;
            state_d = S_DRD;
          end
        end
      end
      S_DRD: begin
        raddr   = base_q + AW'(di_q);
        state_d = S_DWR;
      end
      S_DWR: begin
        raddr = base_q + AW'(di_q);
        if (can_load) begin
          out_load          = 1'b1;
          out_d.code_byte   = rdata_q.data;
          out_d.row_done    = lastd;
          out_d.stream_done = lastd && last_q;
          if (lastd) begin
            // Row complete: drop its bytes from the window.
            seq_d  = seq_q + 4'd1;
            base_d = base_q + AW'(len_q);
            fill_d = fill_after;
            if (!flush_q) begin
              state_d = S_IDLE;
            end else if (fill_after == '0) begin
              state_d = S_IDLE;
              base_d  = '0;
              sum_d   = 8'd0;
              seq_d   = 4'd0;
              run_d   = 1'b0;
              dcnt_d  = 8'd0;
              carry_d = 4'd0;
              pend_d  = P_NONE;
              flush_d = 1'b0;
            end else begin
              row_go   = 1'b1;
              row_fill = fill_after;
            end
          end else begin
            di_d    = di_q + LW'(1);
            state_d = S_DRD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Set up the scan of a new row.
    if (row_go) begin
      len_d   = (row_fill < FW'(ROW_BYTES)) ? LW'(row_fill) : LW'(ROW_BYTES);
      last_d  = (row_fill <= FW'(ROW_BYTES));
      peek_d  = !(row_fill <= FW'(ROW_BYTES));
      ri_d    = '0;
      pv_d    = 1'b0;
      first_d = 1'b1;
      ns_d    = 4'd0;
      icnt_d  = 4'd0;
      ne_d    = 4'd0;
      state_d = S_SCAN;
    end

    // Output register.
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      fill_q      <= '0;
      sum_q       <= 8'd0;
      seq_q       <= 4'd0;
      run_q       <= 1'b0;
      dcnt_q      <= 8'd0;
      carry_q     <= 4'd0;
      pend_q      <= P_NONE;
      patch_q     <= 1'b0;
      fx_q        <= 2'd0;
      flush_q     <= 1'b0;
      len_q       <= '0;
      last_q      <= 1'b0;
      peek_q      <= 1'b0;
      ri_q        <= '0;
      pj_q        <= '0;
      pv_q        <= 1'b0;
      first_q     <= 1'b0;
      ns_q        <= 4'd0;
      icnt_q      <= 4'd0;
      ne_q        <= 4'd0;
      hk_q        <= H_COUNT;
      di_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      seq_q       <= seq_d;
      run_q       <= run_d;
      dcnt_q      <= dcnt_d;
      carry_q     <= carry_d;
      pend_q      <= pend_d;
      patch_q     <= patch_d;
      fx_q        <= fx_d;
      flush_q     <= flush_d;
      len_q       <= len_d;
      last_q      <= last_d;
      peek_q      <= peek_d;
      ri_q        <= ri_d;
      pj_q        <= pj_d;
      pv_q        <= pv_d;
      first_q     <= first_d;
      ns_q        <= ns_d;
      icnt_q      <= icnt_d;
      ne_q        <= ne_d;
      hk_q        <= hk_d;
      di_q        <= di_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    prev1_q <= prev1_d;
    prev2_q <= prev2_d;
    out_q   <= out_d;
  end

  // Byte window memory with registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // The window never holds more than its capacity.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(WIN))
    else $error("byte window overfilled");

  // A stream end is always also a row end.
  a_stream_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.stream_done) |-> out_q.row_done)
    else $error("stream end without row end");

  // A row is never scanned empty.
  a_row_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (len_q != '0))
    else $error("empty row scanned");

  // After the final row the window is empty and the block is idle.
  a_flush_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DWR && can_load && lastd && last_q)
      |=> (fill_q == '0 && state_q == S_IDLE && !flush_q))
    else $error("state not cleared after final row");

endmodule

`default_nettype wire

// ----- hdl/program_barcode_row_packer_unit.sv -----
// ----------------------------------------------------------------------------
// Program barcode row packer
// Cuts a program byte stream into instructions and packs it into barcode
// rows with count, checksum, type/sequence and continuation header bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one program byte per word with a final mark on
//   the last byte of a program. The output channel gives one row byte per
//   word with row_done on the last byte of each row and stream_done on the
//   last byte of the final row. Both channels use valid/ready.
//   Input words pass a front register and a two-word queue, so the input
//   keeps accepting while the back end works, until both are full. A row
//   is settled in steps: the instruction scan (one window memory read per
//   cycle), the checksum, four header words and then each data byte, read
//   through the single memory read port and sent to the output register.
//   The final byte starts the END fixup, which writes the three END bytes
//   over the last three program bytes or after them; then all remaining
//   rows are flushed and the block returns to its reset state, ready for the
//   next program.
//   Reset clears all control state; no clearing pass is needed. A stalled
//   receiver holds the output word and the back end waits, while the queue
//   absorbs input words.
// ----------------------------------------------------------------------------
`default_nettype none

module program_barcode_row_packer_unit #(
  parameter int ROW_BYTES = prbp_pkg::ROW_BYTES_DEF,
  parameter int LOOKAHEAD = prbp_pkg::LOOKAHEAD_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire prbp_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output prbp_pkg::out_word_t      out_word_o
);
  import prbp_pkg::*;

  logic    push_valid, push_ready, pop_valid, pop;
  q_item_t push_item, pop_item;

  // Accept and classify.
  prbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // Decoupling queue.
  prbp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  // Window, row scan and emission.
  prbp_back #(
    .ROW_BYTES (ROW_BYTES),
    .LOOKAHEAD (LOOKAHEAD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_pop_o     (pop),
    .q_item_i    (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ----- dv/tb_program_barcode_row_packer_unit.sv -----
// ----------------------------------------------------------------------------
// Testbench for the program barcode row packer
// Feeds program byte streams through the input channel and checks every row
// word against a cycle-free predictor of the packer. A directed table and a
// long digit run come first, then random well-formed programs mixed with
// noise, under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_program_barcode_row_packer_unit;
  import prbp_pkg::*;

  localparam int ROWB = ROW_BYTES_DEF;
  localparam int AHEAD = LOOKAHEAD_DEF;
  localparam int WIN_DEPTH = ROWB + AHEAD + 3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_GOAL = 480;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  program_barcode_row_packer_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  // Clock and cycle limit.
  int cycles = 0;
  initial begin
    clk_i = 1'b0;
    forever begin
      #6 clk_i = ~clk_i;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Packer state mirror.
  logic [7:0] pk_win [WIN_DEPTH];
  int pk_fill, pk_sum, pk_seq, pk_carry, pk_digits;
  bit pk_in_run;
  out_word_t row_words_q [$];

  int errors = 0;
  int sent = 0;
  bit calm = 1'b0;

  function automatic int win_at(int i);
    return (i < pk_fill) ? int'(pk_win[i]) : 0;
  endfunction

  function automatic bit is_digit(int b);
    return b >= int'(DIGIT_LO) && b <= int'(DIGIT_HI);
  endfunction

  function automatic int instr_length(int p);
    int b;
    b = win_at(p);
    case (b >> 4)
      1: return (win_at(p + 1) & 'hf) + 2;
      9, 10, 11: return 2;
      12: begin
        if ((b & 'he) == 'he) return 2;
        if (win_at(p + 2) & 'h80) return (win_at(p + 2) & 'hf) + 3;
        return 3;
      end
      13, 14: return 3;
      15: return (b & 'hf) + 1;
      default: return 1;
    endcase
  endfunction

  function automatic void sum_in(int b);
    int s;
    s = pk_sum + (b & 'hff);
    if (s > 255) s = (s & 'hff) + 1;
    pk_sum = s & 'hff;
  endfunction

  function automatic void reset_packer();
    pk_fill = 0;
    pk_sum = 0;
    pk_seq = 0;
    pk_carry = 0;
    pk_in_run = 1'b0;
    pk_digits = 0;
  endfunction

  function automatic void push_word(int b, bit rd, bit sd);
    out_word_t w;
    w.code_byte = b[7:0];
    w.row_done = rd;
    w.stream_done = sd;
    row_words_q.push_back(w);
  endfunction

  // Settles one row of len bytes from the head of the window.
  function automatic void pack_row(int len, bit last);
    int ns, ne, pos, start, fit, type_b, cont_b;
    ne = 0;
    pos = 0;
    if (pk_in_run) begin
      ns = 0;
      while (ns < len && is_digit(win_at(ns)) && pk_digits + ns < 255) ns++;
    end else begin
      ns = (pk_carry < len) ? pk_carry : len;
    end
    while (pos < len) begin
      start = pos;
      if (!pk_in_run && pk_carry == 0) begin
        if (is_digit(win_at(pos))) begin
          pk_in_run = 1'b1;
          pk_digits = 0;
        end else begin
          pk_carry = instr_length(pos);
        end
      end
      if (pk_in_run) begin
        while (pos < len && is_digit(win_at(pos)) && pk_digits < 255) begin
          pos++;
          pk_digits++;
        end
        if (pos < len) pk_in_run = 1'b0;
        else if (len < pk_fill && is_digit(win_at(len)) && pk_digits < 255) ne = pos - start;
        else pk_in_run = 1'b0;
      end else begin
        fit = len - pos;
        if (pk_carry < fit) fit = pk_carry;
        pos += fit;
        pk_carry -= fit;
        if (pos == len && pk_carry != 0) begin
          if (len < pk_fill) ne = fit;
          else pk_carry = 0;
        end
      end
    end
    type_b = int'(TYPE_BASE) + (pk_seq & 'hf);
    cont_b = ((ns & 'hf) << 4) | (ne & 'hf);
    sum_in(type_b);
    sum_in(cont_b);
    for (int i = 0; i < len; i++) sum_in(win_at(i));
    push_word(len + 2, 1'b0, 1'b0);
    push_word(pk_sum, 1'b0, 1'b0);
    push_word(type_b, 1'b0, 1'b0);
    push_word(cont_b, len == 0, last && len == 0);
    for (int i = 0; i < len; i++) push_word(win_at(i), i + 1 == len, last && i + 1 == len);
    pk_seq = (pk_seq + 1) & 'hf;
    for (int i = 0; i + len < pk_fill; i++) pk_win[i] = pk_win[i + len];
    pk_fill -= len;
  endfunction

  function automatic void win_push(logic [7:0] b);
    if (pk_fill < WIN_DEPTH) begin
      pk_win[pk_fill] = b;
      pk_fill++;
    end
  endfunction

  // Predicts the row words caused by one accepted byte.
  function automatic void pack_byte(logic [7:0] b, bit fin);
    int len;
    win_push(b);
    if (!fin) begin
      if (pk_fill >= ROWB + AHEAD) pack_row(ROWB, 1'b0);
      return;
    end
    if (pk_fill >= 3 && pk_win[pk_fill - 3][7:4] == END_B0[7:4] && !pk_win[pk_fill - 1][7]) begin
      pk_win[pk_fill - 3] = END_B0;
      pk_win[pk_fill - 2] = END_B1;
      pk_win[pk_fill - 1] = END_B2;
    end else begin
      win_push(END_B0);
      win_push(END_B1);
      win_push(END_B2);
    end
    while (pk_fill > 0) begin
      len = (pk_fill < ROWB) ? pk_fill : ROWB;
      pack_row(len, pk_fill == len);
    end
    reset_packer();
  endfunction

  // Result side: compare every accepted word, stall in random bursts.
  initial begin
    int stall;
    stall = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (row_words_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h", out_word_o);
        end else if (out_word_o !== row_words_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("word mismatch: expected byte %h rd %b sd %b, got byte %h rd %b sd %b",
                     row_words_q[0].code_byte, row_words_q[0].row_done,
                     row_words_q[0].stream_done, out_word_o.code_byte,
                     out_word_o.row_done, out_word_o.stream_done);
          void'(row_words_q.pop_front());
        end else begin
          void'(row_words_q.pop_front());
        end
      end
      if (stall > 0) stall--;
      else if (!calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 13);
      out_ready_i <= (stall == 0) && rst_ni;
    end
  end

  // Sends one byte; waits for its handshake, then idles at random.
  task automatic send_byte(logic [7:0] b, bit fin, bit typed);
    out_word_t scratch [$];
    in_valid_i <= 1'b1;
    in_word_i <= '{prog_byte: b, final_byte: fin};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
    if (typed) begin
      // A lone NOP gets the END appended: one row 00 C0 00 2F.
      scratch = row_words_q;
      pack_byte(b, fin);
      row_words_q = scratch;
      push_word(8'h06, 0, 0);
      push_word(8'hFF, 0, 0);
      push_word(8'h10, 0, 0);
      push_word(8'h00, 0, 0);
      push_word(8'h00, 0, 0);
      push_word(8'hC0, 0, 0);
      push_word(8'h00, 0, 0);
      push_word(8'h2F, 1, 1);
    end else begin
      pack_byte(b, fin);
    end
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  typedef struct {
    logic [7:0] b;
    bit         fin;
    bit         typed;
  } stim_row_t;

  // Directed table: extremes, each instruction class, END patch and append.
  stim_row_t directed [] = '{
    '{8'h00, 1, 1},
    '{8'hFF, 0, 0}, '{8'h2F, 1, 0},
    '{8'h10, 0, 0}, '{8'h1C, 0, 0}, '{8'h1D, 0, 0}, '{8'h0F, 0, 0},
    '{8'h90, 0, 0}, '{8'hCE, 0, 0}, '{8'h7F, 0, 0}, '{8'hC1, 0, 0},
    '{8'h00, 0, 0}, '{8'h85, 0, 0}, '{8'hD0, 0, 0}, '{8'hE1, 0, 0},
    '{8'hB2, 0, 0}, '{8'hC3, 0, 0}, '{8'h12, 0, 0}, '{8'h05, 1, 0},
    '{8'h80, 0, 0}, '{8'hFF, 1, 0}
  };

  logic [7:0] prog_q [$];

  // Appends one random instruction, mostly well formed.
  task automatic add_instr();
    int n, k;
    logic [7:0] b;
    case ($urandom_range(0, 8))
      0: begin
        b = 8'($urandom_range(0, 'h8F));
        if (b[7:4] == 4'h1) b = b + 8'h10;
        prog_q.push_back(b);
      end
      1: begin
        n = $urandom_range(1, 6);
        repeat (n) prog_q.push_back(8'($urandom_range(DIGIT_LO, DIGIT_HI)));
      end
      2: begin
        b = 8'($urandom);
        prog_q.push_back(8'($urandom_range('h1D, 'h1F)));
        prog_q.push_back(b);
        repeat (b[3:0]) prog_q.push_back(8'($urandom));
      end
      3: begin
        prog_q.push_back(8'($urandom_range('h90, 'hBF)));
        prog_q.push_back(8'($urandom));
      end
      4: begin
        prog_q.push_back(8'($urandom_range('hCE, 'hCF)));
        prog_q.push_back(8'($urandom));
      end
      5: begin
        b = 8'($urandom);
        prog_q.push_back(8'($urandom_range('hC0, 'hCD)));
        prog_q.push_back(8'($urandom));
        prog_q.push_back(b);
        if (b[7]) repeat (b[3:0]) prog_q.push_back(8'($urandom));
      end
      6: begin
        prog_q.push_back(8'($urandom_range('hD0, 'hEF)));
        prog_q.push_back(8'($urandom));
        prog_q.push_back(8'($urandom));
      end
      7: begin
        k = $urandom_range(0, 15);
        prog_q.push_back(8'hF0 | k[7:0]);
        repeat (k) prog_q.push_back(8'($urandom));
      end
      default: prog_q.push_back(8'($urandom));
    endcase
  endtask

  task automatic send_program();
    for (int i = 0; i < prog_q.size(); i++)
      send_byte(prog_q[i], i == prog_q.size() - 1, 1'b0);
    prog_q.delete();
  endtask

  // Stimulus and end of run.
  initial begin
    int waited;
    reset_packer();
    in_valid_i = 1'b0;
    in_word_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_byte(directed[i].b, directed[i].fin, directed[i].typed);

    // A digit run long enough to saturate one digit instruction.
    repeat (262) prog_q.push_back(8'($urandom_range(DIGIT_LO, DIGIT_HI)));
    send_program();

    // Hold off until every row word has drained.
    in_valid_i <= 1'b0;
    while (row_words_q.size() != 0) @(posedge clk_i);

    while (sent < ITEM_GOAL) begin
      if (sent > ITEM_GOAL - 60) calm = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 5)) prog_q.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 14)) add_instr();
        // Ends on a C instruction often, so the in-place fixup is hit.
        if ($urandom_range(0, 2) == 0) begin
          prog_q.push_back(8'($urandom_range('hC0, 'hCD)));
          prog_q.push_back(8'($urandom));
          prog_q.push_back(8'($urandom_range(0, 'h7F)));
        end
      end
      send_program();
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (row_words_q.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (100) @(posedge clk_i);
    if (errors == 0 && row_words_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- program_barcode_row_packer_unit.f -----
hdl/prbp_pkg.sv
hdl/prbp_front.sv
hdl/prbp_fifo.sv
hdl/prbp_back.sv
hdl/program_barcode_row_packer_unit.sv
dv/tb_program_barcode_row_packer_unit.sv
